>>> design/mset_pkg.sv
// Shared constants, codes and types for the event timer bank.
// No dependencies; every other design file but mset_ram refers to this package by scoped name.
package mset_pkg;

    localparam int SLOTS   = 8;
    localparam int TICK_HZ = 1000;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MODE_W  = 3;
    localparam int SLOTF_W = 3;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;
    localparam int SHOW_W  = 8;
    localparam int SHOW_N  = (SLOTS < SHOW_W) ? SLOTS : SHOW_W;

    // Clock starts ten seconds of ticks short of wrapping.
    localparam logic [TIME_W-1:0] TIME_RST = {TIME_W{1'b1}} - TIME_W'(10 * TICK_HZ);

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_ONESHOT = 3'd1,
        MODE_REPEAT  = 3'd2,
        MODE_COUNTED = 3'd3,
        MODE_CANCEL  = 3'd4
    } t_mode;

    typedef struct packed {
        logic [TIME_W-1:0] target;
        logic [TIME_W-1:0] interval;
        logic              rep;
        logic              cnt;
        logic [CNT_W-1:0]  remaining;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              capture;
        logic              adv_time;
        logic              arm_wr;
        logic              cancel;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
        logic              ev_en;
        logic [SLOT_W-1:0] ev_idx;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic is_arm;
        logic is_cancel;
        logic out_free;
    } t_sts;

endpackage

>>> design/mset_if.sv
// Valid/ready channel interfaces for the timer bank request and result.
// Depends on mset_pkg for field widths.
interface mset_req_if;
    logic                              valid;
    logic                              ready;
    logic [mset_pkg::MODE_W-1:0]       mode;
    logic [mset_pkg::SLOTF_W-1:0]      slot;
    logic [mset_pkg::TIME_W-1:0]       duration;
    logic [mset_pkg::CNT_W-1:0]        count;

    modport source (output valid, mode, slot, duration, count, input ready);
    modport sink   (input valid, mode, slot, duration, count, output ready);
endinterface

interface mset_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [mset_pkg::SHOW_W-1:0]       fired;
    logic [mset_pkg::SHOW_W-1:0]       active_mask;
    logic [mset_pkg::TIME_W-1:0]       time_now;

    modport source (output valid, fired, active_mask, time_now, input ready);
    modport sink   (input valid, fired, active_mask, time_now, output ready);
endinterface

>>> design/mset_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/mset_ctrl.sv
// Controller: sequences capture, arm/cancel, the per-slot tick scan and the result load.
// Depends on mset_pkg for command and status types.
module mset_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  mset_pkg::t_sts   i_sts,
    output mset_pkg::t_cmd   o_cmd
);
    localparam int SW = mset_pkg::SLOT_W;
    localparam logic [SW-1:0] LAST = SW'(mset_pkg::SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [SW-1:0]   r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_tick) begin
                    // advance clock and prefetch slot 0
                    o_cmd.adv_time = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_idx   = '0;
                    n_idx          = '0;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.arm_wr = i_sts.is_arm;
                    o_cmd.cancel = i_sts.is_cancel;
                    n_state      = S_FIN;
                end
            end
            S_SCAN: begin
                // evaluate slot r_idx while reading the next one
                o_cmd.ev_en  = 1'b1;
                o_cmd.ev_idx = r_idx;
                o_cmd.rd_idx = r_idx + SW'(1);
                if (r_idx == LAST) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + SW'(1);
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> design/mset_dp.sv
// Datapath: request registers, tick clock, active bits, slot RAM and result register.
// Depends on mset_pkg and mset_ram.
module mset_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mset_pkg::t_cmd                    i_cmd,
    output mset_pkg::t_sts                    o_sts,
    input  logic [mset_pkg::MODE_W-1:0]       i_mode,
    input  logic [mset_pkg::SLOTF_W-1:0]      i_slot,
    input  logic [mset_pkg::TIME_W-1:0]       i_duration,
    input  logic [mset_pkg::CNT_W-1:0]        i_count,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_ready,
    output logic [mset_pkg::SHOW_W-1:0]       o_fired,
    output logic [mset_pkg::SHOW_W-1:0]       o_active_mask,
    output logic [mset_pkg::TIME_W-1:0]       o_time_now
);
    localparam int SW = mset_pkg::SLOT_W;
    localparam int N  = mset_pkg::SLOTS;

    logic [mset_pkg::MODE_W-1:0]  r_mode;
    logic [mset_pkg::SLOTF_W-1:0] r_slot;
    logic [mset_pkg::TIME_W-1:0]  r_dur;
    logic [mset_pkg::CNT_W-1:0]   r_count;
    logic [mset_pkg::TIME_W-1:0]  r_time;
    logic [N-1:0]                 r_active, n_active;
    logic [N-1:0]                 r_fired, n_fired;
    logic                         r_o_valid;
    logic [mset_pkg::SHOW_W-1:0]  r_o_fired, r_o_active;
    logic [mset_pkg::TIME_W-1:0]  r_o_time;

    logic [SW-1:0]                w_sidx;
    logic                         w_slot_ok;
    logic                         w_is_arm, w_is_cancel;
    logic                         w_rep, w_cnt;
    logic                         w_hit;
    logic                         w_we;
    logic [SW-1:0]                w_waddr;
    mset_pkg::t_entry             w_rd, w_wr;
    logic [mset_pkg::ENTRY_W-1:0] w_rdata;
    logic [mset_pkg::SHOW_W-1:0]  w_show_fired, w_show_active;

    assign w_sidx    = SW'(r_slot);
    assign w_slot_ok = (32'(r_slot) < 32'(N));

    always_comb begin
        w_is_arm    = 1'b0;
        w_is_cancel = 1'b0;
        case (r_mode)
            mset_pkg::MODE_ONESHOT, mset_pkg::MODE_REPEAT: w_is_arm = w_slot_ok;
            mset_pkg::MODE_COUNTED: begin
                w_is_arm    = w_slot_ok && (r_count != '0);
                w_is_cancel = w_slot_ok && (r_count == '0);
            end
            mset_pkg::MODE_CANCEL: w_is_cancel = w_slot_ok;
            default: ;
        endcase
    end

    assign w_rep = (r_mode == mset_pkg::MODE_REPEAT) || (r_mode == mset_pkg::MODE_COUNTED);
    assign w_cnt = (r_mode == mset_pkg::MODE_COUNTED);

    assign o_sts.is_tick   = (r_mode == mset_pkg::MODE_TICK);
    assign o_sts.is_arm    = w_is_arm;
    assign o_sts.is_cancel = w_is_cancel;
    assign o_sts.out_free  = !r_o_valid || i_rsp_ready;

    assign w_rd  = mset_pkg::t_entry'(w_rdata);
    assign w_hit = i_cmd.ev_en && r_active[i_cmd.ev_idx] && (w_rd.target == r_time);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_cmd.ev_idx;
        w_wr    = w_rd;
        if (i_cmd.arm_wr) begin
            w_we           = 1'b1;
            w_waddr        = w_sidx;
            w_wr.target    = r_time + r_dur;
            w_wr.interval  = w_rep ? r_dur : '0;
            w_wr.rep       = w_rep;
            w_wr.cnt       = w_cnt;
            w_wr.remaining = w_cnt ? r_count : '0;
        end else if (w_hit && w_rd.rep) begin
            w_we        = 1'b1;
            w_wr.target = w_rd.target + w_rd.interval;
            if (w_rd.cnt) begin
                w_wr.remaining = w_rd.remaining - mset_pkg::CNT_W'(1);
            end
        end
    end

    mset_ram #(
        .WIDTH (mset_pkg::ENTRY_W),
        .DEPTH (N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_active = r_active;
        n_fired  = r_fired;
        if (i_cmd.capture) begin
            n_fired = '0;
        end
        if (i_cmd.cancel) begin
            n_active[w_sidx] = 1'b0;
        end
        if (i_cmd.arm_wr) begin
            n_active[w_sidx] = 1'b1;
        end
        if (w_hit) begin
            n_fired[i_cmd.ev_idx] = 1'b1;
            // one-shot ends; counted ends on its last firing
            if (!w_rd.rep || (w_rd.cnt && (w_rd.remaining == mset_pkg::CNT_W'(1)))) begin
                n_active[i_cmd.ev_idx] = 1'b0;
            end
        end
    end

    always_comb begin
        w_show_fired  = '0;
        w_show_active = '0;
        for (int i = 0; i < mset_pkg::SHOW_N; i++) begin
            w_show_fired[i]  = r_fired[i];
            w_show_active[i] = r_active[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= mset_pkg::TIME_RST;
            r_active  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            if (i_cmd.adv_time) begin
                r_time <= r_time + mset_pkg::TIME_W'(1);
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fired <= n_fired;
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_slot  <= i_slot;
            r_dur   <= i_duration;
            r_count <= i_count;
        end
        if (i_cmd.load_out) begin
            r_o_fired  <= w_show_fired;
            r_o_active <= w_show_active;
            r_o_time   <= r_time;
        end
    end

    assign o_rsp_valid   = r_o_valid;
    assign o_fired       = r_o_fired;
    assign o_active_mask = r_o_active;
    assign o_time_now    = r_o_time;
endmodule

>>> design/multi_slot_event_timer_bank_core.sv
// Top level of the event timer bank: joins controller and datapath to the channels.
// Depends on mset_pkg, mset_if, mset_ctrl, mset_dp.
//
// Usage: requests arrive on i_req (mode, slot, duration, count). Mode tick advances
// the 32-bit clock and fires every active slot whose target equals the new time;
// modes arm one-shot, repeating and counted slots, or cancel one. Each request gives
// exactly one result on o_rsp: fired slots (ticks only), active slots and the clock.
// Sequence: an arm or cancel request goes through decode and finish, where it waits for
// room in the result register, before its result is loaded there; a tick also runs the
// scan between them, which reads, checks and writes back one slot per cycle through the
// slot RAM's separate read and write ports.
// One request is worked on at a time; the next is accepted as soon as the current
// result sits in the output register, so a stalled receiver holds at most one result
// while one more request is in progress.
// Reset (synchronous, active low) clears all slots and sets the clock to ten seconds
// of ticks before wrap; slot parameters are not cleared and are only used for
// active slots.
module multi_slot_event_timer_bank_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mset_req_if.sink    i_req,
    mset_rsp_if.source  o_rsp
);
    mset_pkg::t_cmd w_cmd;
    mset_pkg::t_sts w_sts;
    logic           w_req_ready;

    mset_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mset_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_mode        (i_req.mode),
        .i_slot        (i_req.slot),
        .i_duration    (i_req.duration),
        .i_count       (i_req.count),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_fired       (o_rsp.fired),
        .o_active_mask (o_rsp.active_mask),
        .o_time_now    (o_rsp.time_now)
    );

    assign i_req.ready = w_req_ready;
endmodule

>>> design/mset_chk.sv
// Port-level checker for the timer bank, bound to the top level.
// Depends on mset_pkg for field widths.
module mset_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [mset_pkg::TIME_W-1:0]  i_time_now
);
    // result held while the receiver stalls
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_time_now))
        else $error("result dropped or changed while stalled");

    // a request, once taken, makes the block busy and drops ready
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one in progress");

    // a new result only appears after work that blocked requests
    a_rsp_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_ready))
        else $error("result appeared without a request in progress");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");
endmodule

bind multi_slot_event_timer_bank_core mset_chk u_mset_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_time_now  (o_rsp.time_now)
);

>>> test/multi_slot_event_timer_bank_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the event timer bank: a predictor tracks the clock and slots
// and every result is checked against it. Depends on mset_pkg, mset_if and the core.
module multi_slot_event_timer_bank_core_tb;

    localparam logic [2:0]  MODE_SPARE_A   = 3'd5;
    localparam logic [2:0]  MODE_SPARE_C   = 3'd7;
    localparam logic [31:0] CLOCK_AT_RESET = 32'hFFFF_FFFF - 32'(10 * mset_pkg::TICK_HZ);
    localparam int          HOLD_CYCLES    = 400;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int unsigned LIMIT_CYCLES   = 500000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  slot;
        logic [31:0] dur;
        logic [15:0] cnt;
    } t_timer_req;

    typedef struct packed {
        logic [7:0]  fired;
        logic [7:0]  active;
        logic [31:0] now;
    } t_bank_view;

    logic i_clk;
    logic i_rst_n;

    mset_req_if req_ch ();
    mset_rsp_if rsp_ch ();

    multi_slot_event_timer_bank_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // predicted bank state
    logic [31:0] clock_now;
    bit          armed      [mset_pkg::SLOTS];
    logic [31:0] due_at     [mset_pkg::SLOTS];
    logic [31:0] period     [mset_pkg::SLOTS];
    bit          periodic   [mset_pkg::SLOTS];
    bit          counted    [mset_pkg::SLOTS];
    logic [15:0] shots_left [mset_pkg::SLOTS];

    t_bank_view  pending_views[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    logic        rsp_hold;
    event        hold_kick;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void load_slot(int s, logic [31:0] dur, bit rep, bit cnt,
                                      logic [15:0] n);
        armed[s]      = 1'b1;
        due_at[s]     = clock_now + dur;
        periodic[s]   = rep;
        period[s]     = rep ? dur : 32'd0;
        counted[s]    = cnt;
        shots_left[s] = n;
    endfunction

    function automatic t_bank_view predict_bank_view(t_timer_req r);
        t_bank_view v;
        int         s;
        v = '0;
        s = int'(r.slot);
        if (r.mode == mset_pkg::MODE_TICK) begin
            clock_now = clock_now + 32'd1;
            for (int i = 0; i < mset_pkg::SLOTS; i++) begin
                if (armed[i] && due_at[i] == clock_now) begin
                    if (i < mset_pkg::SHOW_N) v.fired[i] = 1'b1;
                    if (periodic[i]) begin
                        due_at[i] = due_at[i] + period[i];
                        if (counted[i]) begin
                            shots_left[i] = shots_left[i] - 16'd1;
                            if (shots_left[i] == 16'd0) armed[i] = 1'b0;
                        end
                    end else begin
                        armed[i] = 1'b0;
                    end
                end
            end
        end else if (r.mode <= mset_pkg::MODE_CANCEL && s < mset_pkg::SLOTS) begin
            armed[s] = 1'b0;
            case (r.mode)
                mset_pkg::MODE_ONESHOT: begin
                    load_slot(s, r.dur, 1'b0, 1'b0, 16'd0);
                end
                mset_pkg::MODE_REPEAT: begin
                    load_slot(s, r.dur, 1'b1, 1'b0, 16'd0);
                end
                mset_pkg::MODE_COUNTED: begin
                    // a zero count leaves the slot cancelled
                    if (r.cnt != 16'd0) load_slot(s, r.dur, 1'b1, 1'b1, r.cnt);
                end
                default: begin
                end
            endcase
        end
        for (int i = 0; i < mset_pkg::SHOW_N; i++) v.active[i] = armed[i];
        v.now = clock_now;
        return v;
    endfunction

    function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_bank_view got;
        t_bank_view want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.fired, rsp_ch.active_mask, rsp_ch.time_now};
            if (pending_views.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h",
                         $time, got.fired, got.active, got.now);
                mismatches++;
            end else begin
                want = pending_views.pop_front();
                compare_field("fired", 32'(want.fired), 32'(got.fired));
                compare_field("active_mask", 32'(want.active), 32'(got.active));
                compare_field("time_now", want.now, got.now);
            end
        end
        rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
    end

    // long receiver hold-off, counted here
    initial begin
        rsp_hold <= 1'b0;
        forever begin
            @(hold_kick);
            @(posedge i_clk);
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rsp_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("multi_slot_event_timer_bank_core_tb failed");
            $finish;
        end
    end

    task automatic send_request(input logic [2:0] mode, input logic [2:0] slot,
                                input logic [31:0] dur, input logic [15:0] cnt);
        t_timer_req r;
        r = {mode, slot, dur, cnt};
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= mode;
        req_ch.slot     <= slot;
        req_ch.duration <= dur;
        req_ch.count    <= cnt;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_views.push_back(predict_bank_view(r));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_views.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(mset_pkg::MODE_TICK, 3'd0, 32'd0, 16'd0);
        send_request(mset_pkg::MODE_ONESHOT, 3'd0, 32'd1, 16'd0);
        send_request(mset_pkg::MODE_TICK, 3'd0, 32'd0, 16'd0);
        // zero duration: target is now, fires only after a full wrap
        send_request(mset_pkg::MODE_ONESHOT, 3'd7, 32'd0, 16'd0);
        send_request(mset_pkg::MODE_REPEAT, 3'd1, 32'd2, 16'd0);
        send_request(mset_pkg::MODE_COUNTED, 3'd2, 32'd1, 16'd2);
        send_request(mset_pkg::MODE_TICK, 3'd0, 32'd0, 16'd0);
        send_request(mset_pkg::MODE_TICK, 3'd0, 32'd0, 16'd0);
        // zero count cancels the repeating slot
        send_request(mset_pkg::MODE_COUNTED, 3'd1, 32'd5, 16'd0);
        send_request(mset_pkg::MODE_ONESHOT, 3'd3, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(mset_pkg::MODE_ONESHOT, 3'd3, 32'd1, 16'd0);
        send_request(mset_pkg::MODE_REPEAT, 3'd6, 32'd0, 16'd0);
        send_request(mset_pkg::MODE_COUNTED, 3'd4, 32'd1, 16'hFFFF);
        send_request(mset_pkg::MODE_ONESHOT, 3'd5, 32'd1, 16'd0);
        send_request(mset_pkg::MODE_TICK, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(mset_pkg::MODE_TICK, 3'd0, 32'd0, 16'd0);
        send_request(MODE_SPARE_A, 3'd7, 32'd1, 16'd1);
        send_request(MODE_SPARE_A + 3'd1, 3'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(MODE_SPARE_C, 3'd3, 32'd0, 16'd0);
        send_request(mset_pkg::MODE_CANCEL, 3'd7, 32'd0, 16'd0);
        send_request(mset_pkg::MODE_CANCEL, 3'd5, 32'd0, 16'd0);
        send_request(mset_pkg::MODE_CANCEL, 3'd6, 32'd0, 16'd0);
        send_request(mset_pkg::MODE_CANCEL, 3'd4, 32'd0, 16'd0);
    endtask

    task automatic test_random_phase(input int n, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        logic [2:0]  mode;
        logic [31:0] dur;
        logic [15:0] cnt;
        int unsigned pick;
        wait_drained();
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 45)      mode = mset_pkg::MODE_TICK;
            else if (pick < 60) mode = mset_pkg::MODE_ONESHOT;
            else if (pick < 72) mode = mset_pkg::MODE_REPEAT;
            else if (pick < 85) mode = mset_pkg::MODE_COUNTED;
            else if (pick < 95) mode = mset_pkg::MODE_CANCEL;
            else                mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
            // short delays so slots actually fire; some full-width ones
            pick = $urandom_range(99);
            if (pick < 80)      dur = $urandom_range(0, 12);
            else if (pick < 90) dur = $urandom_range(0, 300);
            else                dur = $urandom();
            pick = $urandom_range(99);
            if (pick < 70)      cnt = 16'($urandom_range(0, 4));
            else if (pick < 90) cnt = 16'($urandom_range(0, 40));
            else                cnt = 16'($urandom());
            send_request(mode, 3'($urandom_range(0, 7)), dur, cnt);
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        -> hold_kick;
        repeat (30) begin
            send_request($urandom_range(1) ? mset_pkg::MODE_TICK : mset_pkg::MODE_REPEAT,
                         3'($urandom_range(0, 7)), 32'($urandom_range(1, 4)), 16'd0);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= mset_pkg::MODE_TICK;
        req_ch.slot     <= 3'd0;
        req_ch.duration <= 32'd0;
        req_ch.count    <= 16'd0;
        clock_now = CLOCK_AT_RESET;
        for (int i = 0; i < mset_pkg::SLOTS; i++) begin
            armed[i]      = 1'b0;
            due_at[i]     = 32'd0;
            period[i]     = 32'd0;
            periodic[i]   = 1'b0;
            counted[i]    = 1'b0;
            shots_left[i] = 16'd0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(300, 0, 0);
        test_random_phase(300, 47, 0);
        test_random_phase(300, 0, 47);
        test_random_phase(300, 6, 6);
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("multi_slot_event_timer_bank_core_tb passed");
        end else begin
            $display("multi_slot_event_timer_bank_core_tb failed");
        end
        $finish;
    end

endmodule
